/* rtl/core/u8dec_pkg.sv */
// shared types, constants and helpers for the lenient utf-8 stream decoder
package u8dec_pkg;

	localparam int unsigned CP_W = 31;

	localparam logic [CP_W-1:0] REPL_RESET = CP_W'(63);

	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] CONT_LIMIT  = 8'hc0;
	localparam logic [7:0] LEAD_MIN    = 8'hc2;
	localparam logic [7:0] LEAD_3      = 8'he0;
	localparam logic [7:0] LEAD_4      = 8'hf0;
	localparam logic [7:0] LEAD_5      = 8'hf8;
	localparam logic [7:0] LEAD_6      = 8'hfc;
	localparam logic [7:0] LEAD_BAD    = 8'hfe;

	localparam logic [7:0] MIN_3     = 8'ha0;
	localparam logic [7:0] MIN_4     = 8'h90;
	localparam logic [7:0] MIN_5     = 8'h88;
	localparam logic [7:0] MIN_6     = 8'h84;
	localparam logic [7:0] MIN_PLAIN = 8'h80;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_string;
	} u8dec_in_t;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            was_invalid;
		logic            last_of_run;
	} u8dec_out_t;

	// lowest legal second byte for a given lead (overlong rejection)
	function automatic logic [7:0] second_min(input logic [7:0] lead);
		logic [7:0] m;
		unique case (lead)
			LEAD_3:  m = MIN_3;
			LEAD_4:  m = MIN_4;
			LEAD_5:  m = MIN_5;
			LEAD_6:  m = MIN_6;
			default: m = MIN_PLAIN;
		endcase
		return m;
	endfunction

endpackage

/* rtl/core/utf8_lenient_stream_decoder_core.sv */
// lenient utf-8 byte stream decoder, one byte per word in, one code point per word out
// path: input register, combinational decode step, then the result register
// throughput: one byte per cycle while the output is not stalled; a byte that ends a
//   cut-short sequence gives two results, which take turns on the single output port
// reset: arst_n clears the pipeline, the decode state and sets the replacement to '?'
module utf8_lenient_stream_decoder_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  u8dec_pkg::u8dec_in_t  byte_data,
	output logic                  cp_valid,
	input  logic                  cp_stall,
	output u8dec_pkg::u8dec_out_t cp_data,
	input  logic                  cfg_we,
	input  logic [u8dec_pkg::CP_W-1:0] cfg_data
);
	import u8dec_pkg::*;

	logic [CP_W-1:0] repl_q;

	// input register
	logic            valid_s1;
	u8dec_in_t       data_s1;

	// decode state
	logic [2:0]      rem_q;
	logic [CP_W-1:0] acc_q;
	logic [7:0]      lead_q;
	logic            second_q;
	logic            bad_q;

	// result register, up to two results, head always in slot 0
	logic [1:0]      cnt_s2;
	u8dec_out_t      res0_s2;
	u8dec_out_t      res1_s2;

	// step outputs
	logic [1:0]      step_n;
	u8dec_out_t      step_r0;
	u8dec_out_t      step_r1;
	logic [2:0]      rem_d;
	logic [CP_W-1:0] acc_d;
	logic [7:0]      lead_d;
	logic            second_d;
	logic            bad_d;

	logic            pop;
	logic            s2_free;
	logic            adv_s1;

	always_comb begin
		logic [7:0]      b;
		logic            eos;
		logic [7:0]      minv;
		logic            bad_n;
		logic [CP_W-1:0] acc_n;
		logic [2:0]      rem_n;
		logic            cut;
		logic            lead_has;
		u8dec_out_t      lead_res;

		b        = data_s1.in_byte;
		eos      = data_s1.end_of_string;
		step_n   = 2'd0;
		step_r0  = '{code_point: repl_q, was_invalid: 1'b1, last_of_run: 1'b1};
		step_r1  = step_r0;
		rem_d    = rem_q;
		acc_d    = acc_q;
		lead_d   = lead_q;
		second_d = second_q;
		bad_d    = bad_q;
		minv     = second_q ? second_min(lead_q) : MIN_PLAIN;
		bad_n    = bad_q | (b >= CONT_LIMIT) | (b < minv);
		acc_n    = {acc_q[CP_W-7:0], b[5:0]};
		rem_n    = rem_q - 3'd1;
		cut      = 1'b0;
		lead_has = 1'b0;
		lead_res = step_r0;

		if (rem_q != 3'd0 && b[7]) begin
			// continuation position
			if (rem_n == 3'd0 || eos) begin
				step_n = 2'd1;
				if (rem_n == 3'd0 && !bad_n) begin
					step_r0 = '{code_point: acc_n, was_invalid: 1'b0, last_of_run: 1'b1};
				end
				rem_d    = 3'd0;
				acc_d    = '0;
				lead_d   = '0;
				second_d = 1'b0;
				bad_d    = 1'b0;
			end else begin
				rem_d    = rem_n;
				acc_d    = acc_n;
				second_d = 1'b0;
				bad_d    = bad_n;
			end
		end else begin
			// top bit clear while pending closes the sequence first
			if (rem_q != 3'd0) begin
				cut      = 1'b1;
				step_r0  = '{code_point: repl_q, was_invalid: 1'b1, last_of_run: 1'b0};
				rem_d    = 3'd0;
				acc_d    = '0;
				lead_d   = '0;
				second_d = 1'b0;
				bad_d    = 1'b0;
			end
			priority if (b < ASCII_LIMIT) begin
				lead_has = 1'b1;
				lead_res = '{code_point: CP_W'(b), was_invalid: 1'b0, last_of_run: 1'b1};
			end else if (b < LEAD_MIN || b >= LEAD_BAD || eos) begin
				lead_has = 1'b1;
			end else begin
				priority if (b < LEAD_3) begin
					rem_d = 3'd1;
					acc_d = CP_W'(b[4:0]);
				end else if (b < LEAD_4) begin
					rem_d = 3'd2;
					acc_d = CP_W'(b[3:0]);
				end else if (b < LEAD_5) begin
					rem_d = 3'd3;
					acc_d = CP_W'(b[2:0]);
				end else if (b < LEAD_6) begin
					rem_d = 3'd4;
					acc_d = CP_W'(b[1:0]);
				end else begin
					rem_d = 3'd5;
					acc_d = CP_W'(b[0]);
				end
				lead_d   = b;
				second_d = 1'b1;
				bad_d    = 1'b0;
			end
			if (cut) begin
				step_r1 = lead_res;
				step_n  = 2'd2;
			end else begin
				step_r0 = lead_res;
				step_n  = lead_has ? 2'd1 : 2'd0;
			end
		end
	end

	assign pop        = cp_valid & ~cp_stall;
	assign s2_free    = (cnt_s2 == 2'd0) || (cnt_s2 == 2'd1 && pop);
	assign adv_s1     = valid_s1 & (s2_free | (step_n == 2'd0));
	assign byte_stall = valid_s1 & ~adv_s1;
	assign cp_valid   = cnt_s2 != 2'd0;
	assign cp_data    = res0_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q <= REPL_RESET;
		end else if (cfg_we) begin
			repl_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			data_s1 <= byte_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q    <= '0;
			acc_q    <= '0;
			lead_q   <= '0;
			second_q <= 1'b0;
			bad_q    <= 1'b0;
		end else if (adv_s1) begin
			rem_q    <= rem_d;
			acc_q    <= acc_d;
			lead_q   <= lead_d;
			second_q <= second_d;
			bad_q    <= bad_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
		end else if (adv_s1 && step_n != 2'd0) begin
			cnt_s2 <= step_n;
		end else if (pop) begin
			cnt_s2 <= cnt_s2 - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && step_n != 2'd0) begin
			res0_s2 <= step_r0;
			res1_s2 <= step_r1;
		end else if (pop) begin
			res0_s2 <= res1_s2;
		end
	end

endmodule

/* rtl/core/u8dec_checker.sv */
// port-level checks for the lenient utf-8 decoder, bound to the decoder core
module u8dec_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  byte_valid,
	input logic                  byte_stall,
	input u8dec_pkg::u8dec_in_t  byte_data,
	input logic                  cp_valid,
	input logic                  cp_stall,
	input u8dec_pkg::u8dec_out_t cp_data
);
	import u8dec_pkg::*;

	// a stalled input word stays offered and unchanged
	assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |=> byte_valid && $stable(byte_data))
		else $error("stalled input word changed");

	// a held result does not change while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		cp_valid && cp_stall |=> cp_valid && $stable(cp_data))
		else $error("stalled result changed");

	// only the cut-short replacement can be followed by a second result
	assert property (@(posedge clk) disable iff (!arst_n)
		cp_valid && !cp_data.last_of_run |-> cp_data.was_invalid)
		else $error("non-final result is not a replacement");

	// the second result of a byte is ready right after the first one goes
	assert property (@(posedge clk) disable iff (!arst_n)
		cp_valid && !cp_stall && !cp_data.last_of_run |=> cp_valid && cp_data.last_of_run)
		else $error("second result of a byte missing");

endmodule

bind utf8_lenient_stream_decoder_core u8dec_checker u_u8dec_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.byte_valid (byte_valid),
	.byte_stall (byte_stall),
	.byte_data  (byte_data),
	.cp_valid   (cp_valid),
	.cp_stall   (cp_stall),
	.cp_data    (cp_data)
);
